/* rtl/core/ole_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ole_pkg: shared types and constants of the ordered list engine
// Port field widths, action and status codes, sequencer states, and the
// request and result words passed between the top level and the sequencer.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int unsigned DEF_DEPTH     = 64;
  localparam int unsigned DEF_ITEM_BITS = 32;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned POS2_W   = 6;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FIDX_W   = 6;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND    = 3'd0,
    ACT_INSERT    = 3'd1,
    ACT_DELETE    = 3'd2,
    ACT_OVERWRITE = 3'd3,
    ACT_SWAP      = 3'd4,
    ACT_READ      = 3'd5,
    ACT_FIND      = 3'd6,
    ACT_CLEAR     = 3'd7
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_POS   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_PUT,
    S_DOWN,
    S_FIND,
    S_RD,
    S_SW1,
    S_SW2,
    S_SW3
  } state_e;

  typedef struct packed {
    action_e             action;
    logic [POS_W-1:0]    position;
    logic [POS2_W-1:0]   second_position;
    logic [VALUE_W-1:0]  item_value;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [VALUE_W-1:0]  read_value;
    logic [FIDX_W-1:0]   found_index;
    logic [COUNT_W-1:0]  item_count;
  } res_t;

endpackage
`default_nettype wire

/* rtl/core/ole_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ole_ram: generic single-clock ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ole_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/core/ole_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ole_seq: list sequencer
// Holds the item count, walks the item ram one entry per cycle with a single
// pointer and one equality compare, and builds the result word.
// ----------------------------------------------------------------------------
module ole_seq #(
  parameter int unsigned DEPTH     = ole_pkg::DEF_DEPTH,
  parameter int unsigned ITEM_BITS = ole_pkg::DEF_ITEM_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          go_i,
  input  wire ole_pkg::req_t req_i,
  output logic               busy_o,
  output logic               done_o,
  output ole_pkg::res_t      res_o
);

  import ole_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        wptr_q, wptr_d;
  logic [ITEM_BITS-1:0] tmp_q, tmp_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ITEM_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [ITEM_BITS-1:0] ram_rdata;

  logic [PW-1:0]        pos_e, pos2_e, cnt_e;
  logic [AW-1:0]        pos_a, pos2_a, cnt_a;
  logic [ITEM_BITS-1:0] val_w;
  logic                 full;

  status_e              stat;
  logic [ITEM_BITS-1:0] rd_val;
  logic [AW-1:0]        fidx;

  ole_ram #(
    .WIDTH (ITEM_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign pos_e  = PW'(req_i.position);
  assign pos2_e = PW'(req_i.second_position);
  assign cnt_e  = PW'(count_q);
  assign pos_a  = AW'(req_i.position);
  assign pos2_a = AW'(req_i.second_position);
  assign cnt_a  = AW'(count_q);
  assign val_w  = ITEM_BITS'(req_i.item_value);
  assign full   = (count_q == CW'(DEPTH));

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      wptr_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      wptr_q  <= wptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q <= tmp_d;
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    wptr_d    = wptr_q;
    tmp_d     = tmp_q;
    ram_we    = 1'b0;
    ram_waddr = wptr_q;
    ram_wdata = ram_rdata;
    ram_raddr = wptr_q;
    done_o    = 1'b0;
    stat      = STAT_OK;
    rd_val    = '0;
    fidx      = '0;

    case (state_q)
      S_IDLE: begin
        if (go_i) begin
          case (req_i.action)
            ACT_APPEND: begin
              done_o = 1'b1;
              if (full) begin
                stat = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_a;
                ram_wdata = val_w;
                count_d   = count_q + CW'(1);
              end
            end
            ACT_INSERT: begin
              if (pos_e > cnt_e) begin
                stat   = STAT_BAD_POS;
                done_o = 1'b1;
              end else if (full) begin
                stat   = STAT_FULL;
                done_o = 1'b1;
              end else if (pos_e == cnt_e) begin
                ram_we    = 1'b1;
                ram_waddr = pos_a;
                ram_wdata = val_w;
                count_d   = count_q + CW'(1);
                done_o    = 1'b1;
              end else begin
                // shift the tail up, starting from the last item
                ram_raddr = cnt_a - AW'(1);
                wptr_d    = cnt_a;
                state_d   = S_UP;
              end
            end
            ACT_DELETE: begin
              if (pos_e >= cnt_e) begin
                stat   = STAT_BAD_POS;
                done_o = 1'b1;
              end else if (pos_e + PW'(1) == cnt_e) begin
                count_d = count_q - CW'(1);
                done_o  = 1'b1;
              end else begin
                ram_raddr = pos_a + AW'(1);
                wptr_d    = pos_a;
                state_d   = S_DOWN;
              end
            end
            ACT_OVERWRITE: begin
              done_o = 1'b1;
              if (pos_e >= cnt_e) begin
                stat = STAT_BAD_POS;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pos_a;
                ram_wdata = val_w;
              end
            end
            ACT_SWAP: begin
              if (pos_e >= cnt_e || pos2_e >= cnt_e) begin
                stat   = STAT_BAD_POS;
                done_o = 1'b1;
              end else begin
                ram_raddr = pos_a;
                state_d   = S_SW1;
              end
            end
            ACT_READ: begin
              if (pos_e >= cnt_e) begin
                stat   = STAT_NOT_FOUND;
                done_o = 1'b1;
              end else begin
                ram_raddr = pos_a;
                state_d   = S_RD;
              end
            end
            ACT_FIND: begin
              if (count_q == '0) begin
                stat   = STAT_NOT_FOUND;
                done_o = 1'b1;
              end else begin
                ram_raddr = '0;
                wptr_d    = '0;
                state_d   = S_FIND;
              end
            end
            ACT_CLEAR: begin
              count_d = '0;
              done_o  = 1'b1;
            end
            default: begin
              done_o = 1'b1;
            end
          endcase
        end
      end

      // read data holds entry wptr-1, moved to wptr
      S_UP: begin
        ram_we    = 1'b1;
        ram_waddr = wptr_q;
        ram_wdata = ram_rdata;
        if (wptr_q == pos_a + AW'(1)) begin
          state_d = S_PUT;
        end else begin
          ram_raddr = wptr_q - AW'(2);
          wptr_d    = wptr_q - AW'(1);
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_a;
        ram_wdata = val_w;
        count_d   = count_q + CW'(1);
        done_o    = 1'b1;
        state_d   = S_IDLE;
      end

      // read data holds entry wptr+1, moved to wptr
      S_DOWN: begin
        ram_we    = 1'b1;
        ram_waddr = wptr_q;
        ram_wdata = ram_rdata;
        if (CW'(wptr_q) + CW'(2) == count_q) begin
          count_d = count_q - CW'(1);
          done_o  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ram_raddr = wptr_q + AW'(2);
          wptr_d    = wptr_q + AW'(1);
        end
      end

      // read data holds entry wptr, the next read is issued here on a mismatch
      S_FIND: begin
        if (ram_rdata == val_w) begin
          fidx    = wptr_q;
          done_o  = 1'b1;
          state_d = S_IDLE;
        end else if (CW'(wptr_q) + CW'(1) == count_q) begin
          stat    = STAT_NOT_FOUND;
          done_o  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ram_raddr = wptr_q + AW'(1);
          wptr_d    = wptr_q + AW'(1);
        end
      end

      S_RD: begin
        rd_val  = ram_rdata;
        done_o  = 1'b1;
        state_d = S_IDLE;
      end

      S_SW1: begin
        tmp_d     = ram_rdata;
        ram_raddr = pos2_a;
        state_d   = S_SW2;
      end

      S_SW2: begin
        ram_we    = 1'b1;
        ram_waddr = pos_a;
        ram_wdata = ram_rdata;
        state_d   = S_SW3;
      end

      S_SW3: begin
        ram_we    = 1'b1;
        ram_waddr = pos2_a;
        ram_wdata = tmp_q;
        done_o    = 1'b1;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_o.status      = stat;
    res_o.read_value  = VALUE_W'(rd_val);
    res_o.found_index = FIDX_W'(fidx);
    res_o.item_count  = COUNT_W'(count_d);
  end

endmodule
`default_nettype wire

/* rtl/core/ordered_list_engine_top.sv */
`default_nettype none
// ordered list engine: append, overwrite, clear and any rejected request need no ram
// walk; the time from accept to the done strobe grows with the items shifted for insert
// and delete and, for find, with the match index or the count on a miss, as the
// sequencer walks its ram one entry a cycle. busy is low again in the strobe cycle.
// the receiver cannot stall; reset clears the count, the ram is not cleared.
// ----------------------------------------------------------------------------
// ordered_list_engine_top: ordered list engine
// Captures the request word, runs the list sequencer and registers the
// result word with its one-cycle done strobe.
// ----------------------------------------------------------------------------
module ordered_list_engine_top #(
  parameter int unsigned DEPTH     = ole_pkg::DEF_DEPTH,
  parameter int unsigned ITEM_BITS = ole_pkg::DEF_ITEM_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [ole_pkg::ACTION_W-1:0]  action_i,
  input  wire logic [ole_pkg::POS_W-1:0]     position_i,
  input  wire logic [ole_pkg::POS2_W-1:0]    second_position_i,
  input  wire logic [ole_pkg::VALUE_W-1:0]   item_value_i,
  output logic                               done_o,
  output logic [ole_pkg::STATUS_W-1:0]       status_o,
  output logic [ole_pkg::VALUE_W-1:0]        read_value_o,
  output logic [ole_pkg::FIDX_W-1:0]         found_index_o,
  output logic [ole_pkg::COUNT_W-1:0]        item_count_o
);

  import ole_pkg::*;

  logic accept;
  logic go_q;
  req_t req_q;
  logic seq_busy;
  logic seq_done;
  res_t seq_res;
  logic done_q;
  res_t res_q;

  assign busy_o = go_q | seq_busy;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      go_q   <= accept;
      done_q <= seq_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.action          <= action_e'(action_i);
      req_q.position        <= position_i;
      req_q.second_position <= second_position_i;
      req_q.item_value      <= item_value_i;
    end
    if (seq_done) begin
      res_q <= seq_res;
    end
  end

  ole_seq #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go_q),
    .req_i  (req_q),
    .busy_o (seq_busy),
    .done_o (seq_done),
    .res_o  (seq_res)
  );

  assign done_o        = done_q;
  assign status_o      = res_q.status;
  assign read_value_o  = res_q.read_value;
  assign found_index_o = res_q.found_index;
  assign item_count_o  = res_q.item_count;

endmodule
`default_nettype wire

/* tb/tb_ordered_list_engine_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_top: self-checking bench for the ordered list engine
// A directed opening covers empty-list, boundary and position errors, then
// random runs alternate between growing, shrinking and churning the list. A
// list-state predictor queues the expected result of every accepted word;
// each done strobe is checked against the oldest one.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_top;
  import ole_pkg::*;

  localparam int unsigned LIST_DEPTH   = DEF_DEPTH;
  localparam int unsigned RANDOM_WORDS = 1330;
  localparam int unsigned QUIET_TAIL   = 150;
  localparam int unsigned STALL_LIMIT  = 2000;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_e;

  class list_scoreboard;
    logic [VALUE_W-1:0] slots [LIST_DEPTH];
    int unsigned        count;
    res_t               expected [$];
    int unsigned        mismatches;

    function new();
      count      = 0;
      mismatches = 0;
    endfunction

    // apply one accepted word to the list image and queue its result
    function void note_request(req_t rq);
      res_t        r;
      logic [VALUE_W-1:0] tmp;
      int          i;
      r = '0;
      r.status = STAT_OK;
      case (rq.action)
        ACT_APPEND: begin
          if (count >= LIST_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            slots[count] = rq.item_value;
            count++;
          end
        end
        ACT_INSERT: begin
          // position is checked before fullness
          if (rq.position > count) begin
            r.status = STAT_BAD_POS;
          end else if (count >= LIST_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            for (i = count; i > rq.position; i--) slots[i] = slots[i-1];
            slots[rq.position] = rq.item_value;
            count++;
          end
        end
        ACT_DELETE: begin
          if (rq.position >= count) begin
            r.status = STAT_BAD_POS;
          end else begin
            for (i = rq.position; i + 1 < count; i++) slots[i] = slots[i+1];
            count--;
          end
        end
        ACT_OVERWRITE: begin
          if (rq.position >= count) r.status = STAT_BAD_POS;
          else slots[rq.position] = rq.item_value;
        end
        ACT_SWAP: begin
          if (rq.position >= count || rq.second_position >= count) begin
            r.status = STAT_BAD_POS;
          end else begin
            tmp = slots[rq.position];
            slots[rq.position] = slots[rq.second_position];
            slots[rq.second_position] = tmp;
          end
        end
        ACT_READ: begin
          if (rq.position >= count) r.status = STAT_NOT_FOUND;
          else r.read_value = slots[rq.position];
        end
        ACT_FIND: begin
          r.status = STAT_NOT_FOUND;
          for (i = 0; i < count; i++) begin
            if (slots[i] == rq.item_value) begin
              r.status = STAT_OK;
              r.found_index = i[FIDX_W-1:0];
              break;
            end
          end
        end
        default: begin
          // clear keeps the stored entries
          count = 0;
        end
      endcase
      r.item_count = count[COUNT_W-1:0];
      expected.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no pending word: status %0d read %h index %0d count %0d",
                   got.status, got.read_value, got.found_index, got.item_count);
        return;
      end
      want = expected.pop_front();
      if (got.status !== want.status || got.read_value !== want.read_value ||
          got.found_index !== want.found_index || got.item_count !== want.item_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d read %h index %0d count %0d, %s",
                   want.status, want.read_value, want.found_index, want.item_count,
                   $sformatf("got status %0d read %h index %0d count %0d",
                             got.status, got.read_value, got.found_index, got.item_count));
      end
    endfunction
  endclass

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic [ACTION_W-1:0] action_i = '0;
  logic [POS_W-1:0]    position_i = '0;
  logic [POS2_W-1:0]   second_position_i = '0;
  logic [VALUE_W-1:0]  item_value_i = '0;
  logic                busy_o;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [VALUE_W-1:0]  read_value_o;
  logic [FIDX_W-1:0]   found_index_o;
  logic [COUNT_W-1:0]  item_count_o;

  list_scoreboard sb;
  int unsigned    stall_cycles = 0;

  ordered_list_engine_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .action_i          (action_i),
    .position_i        (position_i),
    .second_position_i (second_position_i),
    .item_value_i      (item_value_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .read_value_o      (read_value_o),
    .found_index_o     (found_index_o),
    .item_count_o      (item_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result(res_t'({status_o, read_value_o, found_index_o, item_count_o}));
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 7);  // small values give duplicates
    if (r < 20) return '0;
    if (r < 25) return '1;
    return $urandom;
  endfunction

  function automatic action_e pick_action(input mix_e mix);
    action_e     acts [8];
    int unsigned w [8];
    int unsigned r;
    int          k;
    acts = '{ACT_APPEND, ACT_INSERT, ACT_DELETE, ACT_OVERWRITE,
             ACT_SWAP, ACT_READ, ACT_FIND, ACT_CLEAR};
    case (mix)
      MIX_GROW:   w = '{40, 30, 5, 5, 5, 5, 8, 2};
      MIX_SHRINK: w = '{5, 5, 50, 5, 8, 10, 12, 5};
      default:    w = '{13, 13, 13, 13, 13, 13, 17, 5};
    endcase
    r = $urandom_range(0, 99);
    for (k = 0; k < 7; k++) begin
      if (r < w[k]) return acts[k];
      r -= w[k];
    end
    return ACT_CLEAR;
  endfunction

  // call at a rising edge; returns at the edge that accepts the word
  task automatic issue_word(input action_e act, input logic [POS_W-1:0] pos,
                            input logic [POS2_W-1:0] pos2, input logic [VALUE_W-1:0] val);
    req_t rq;
    rq = '{action: act, position: pos, second_position: pos2, item_value: val};
    action_i          <= act;
    position_i        <= pos;
    second_position_i <= pos2;
    item_value_i      <= val;
    start_i           <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_request(rq);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start_i           <= 1'b0;
    action_i          <= ACTION_W'($urandom);
    position_i        <= POS_W'($urandom);
    second_position_i <= POS2_W'($urandom);
    item_value_i      <= $urandom;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_random_word(input mix_e mix);
    action_e            act;
    logic [POS_W-1:0]   pos;
    logic [POS2_W-1:0]  pos2;
    logic [VALUE_W-1:0] val;
    int unsigned        cnt;
    int unsigned        r;
    cnt = sb.count;
    act = pick_action(mix);
    r = $urandom_range(0, 99);
    if (r < 80) begin
      if (act == ACT_INSERT) pos = POS_W'($urandom_range(0, cnt));
      else if (cnt == 0) pos = '0;
      else pos = POS_W'($urandom_range(0, cnt - 1));
    end else if (r < 95) begin
      pos = POS_W'($urandom_range(0, LIST_DEPTH));
    end else begin
      pos = POS_W'($urandom_range(0, 127));
    end
    if (cnt > 0 && $urandom_range(0, 99) < 80) pos2 = POS2_W'($urandom_range(0, cnt - 1));
    else pos2 = POS2_W'($urandom_range(0, 63));
    if (act == ACT_FIND && cnt > 0 && $urandom_range(0, 99) < 60)
      val = sb.slots[$urandom_range(0, cnt - 1)];
    else
      val = pick_value();
    issue_word(act, pos, pos2, val);
  endtask

  initial begin
    int unsigned sent;
    int unsigned seg_len;
    int unsigned k;
    mix_e        mix;
    bit          gaps;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty list
    issue_word(ACT_READ,      7'd0,   6'd0,  32'h0);
    issue_word(ACT_FIND,      7'd0,   6'd0,  32'h0);
    issue_word(ACT_DELETE,    7'd0,   6'd0,  32'h0);
    issue_word(ACT_OVERWRITE, 7'd0,   6'd0,  32'h1);
    issue_word(ACT_SWAP,      7'd0,   6'd0,  32'h0);
    issue_word(ACT_INSERT,    7'd1,   6'd0,  32'h2);
    // build a short list with a duplicate
    issue_word(ACT_INSERT,    7'd0,   6'd0,  32'hffff_ffff);
    issue_word(ACT_APPEND,    7'd0,   6'd0,  32'h0);
    issue_word(ACT_INSERT,    7'd1,   6'd0,  32'h1234_5678);
    issue_word(ACT_APPEND,    7'd127, 6'd63, 32'h0);
    issue_word(ACT_FIND,      7'd0,   6'd0,  32'h0);
    issue_word(ACT_FIND,      7'd0,   6'd0,  32'hffff_ffff);
    pause_sender(3);
    issue_word(ACT_SWAP,      7'd0,   6'd3,  32'h0);
    issue_word(ACT_SWAP,      7'd2,   6'd2,  32'h0);
    issue_word(ACT_SWAP,      7'd1,   6'd63, 32'h0);
    issue_word(ACT_OVERWRITE, 7'd3,   6'd0,  32'ha5a5_a5a5);
    issue_word(ACT_READ,      7'd3,   6'd0,  32'h0);
    issue_word(ACT_READ,      7'd64,  6'd0,  32'h0);
    issue_word(ACT_INSERT,    7'd64,  6'd0,  32'h5a5a_5a5a);
    issue_word(ACT_DELETE,    7'd1,   6'd0,  32'h0);
    issue_word(ACT_DELETE,    7'd2,   6'd0,  32'h0);
    issue_word(ACT_FIND,      7'd0,   6'd0,  32'h1234_5678);
    issue_word(ACT_READ,      7'd127, 6'd0,  32'h0);
    issue_word(ACT_CLEAR,     7'd0,   6'd0,  32'h0);
    issue_word(ACT_FIND,      7'd0,   6'd0,  32'h0);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      mix = mix_e'($urandom_range(0, 2));
      seg_len = $urandom_range(20, 100);
      gaps = ($urandom_range(0, 2) != 0);
      for (k = 0; k < seg_len && sent < RANDOM_WORDS; k++) begin
        send_random_word(mix);
        sent++;
        if (gaps && sent + QUIET_TAIL < RANDOM_WORDS && $urandom_range(0, 3) == 0)
          pause_sender($urandom_range(1, 14));
      end
    end
    start_i <= 1'b0;

    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (LIST_DEPTH + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
